FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ETM_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("etm assertion failed");

// next-cycle implication
`define ETM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("etm assertion failed");

`endif

FILE: rtl/etm_pkg.sv
// ---------------------------------------------------------------------------
// etm_pkg
// types, constants and fixed-point helpers for the euler transform block
// ---------------------------------------------------------------------------
package etm_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 16;

  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int ELEM_W = TRIG_FRAC_BITS + 3;
  localparam int MUL_W  = (ELEM_W > 16) ? ELEM_W : 16;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SAT_W  = PROD_W + 1;

  localparam int NUMW   = ELEM_W + 24 - TRIG_FRAC_BITS;
  localparam int REMW   = 17;
  localparam int DIV_LAT = NUMW + 2;
  localparam int SIN_LAT = 5;
  localparam int RT_LAT  = 2;
  localparam int SIDE_LAT = SIN_LAT + RT_LAT;

  localparam int NUM_RES = 7;
  localparam logic [2:0] LAST_IDX   = 3'(NUM_RES - 1);
  localparam logic [2:0] ACCEPT_GAP = 3'(NUM_RES - 1);

  localparam logic [31:0] PHASE_MASK   = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic [30:0] K_A     = 31'd1686629713;
  localparam logic [29:0] K_B     = 30'd688904866;
  localparam logic [26:0] K_C     = 27'd76016977;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [32:0] SIN_RND = 33'd1 << (29 - TRIG_FRAC_BITS);

  localparam logic signed [SAT_W-1:0] MAX32 = SAT_W'(2147483647);
  localparam logic signed [SAT_W-1:0] MIN32 = -MAX32 - SAT_W'(1);

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [2:0] vec_t;
  typedef vec_t [2:0] mat_t;
  typedef logic signed [15:0] scale_t;
  typedef logic signed [31:0] word_t;

  typedef struct packed {
    trig_t s1;
    trig_t c1;
    trig_t s2;
    trig_t c2;
    trig_t s3;
    trig_t c3;
  } trig_set_t;

  typedef struct packed {
    scale_t [2:0] sc;
    word_t [2:0]  tr;
  } side_t;

  typedef struct packed {
    mat_t  m;
    side_t s;
  } late_t;

  typedef struct packed {
    word_t [2:0] e;
    logic        zs;
  } res_t;

  // sign-magnitude product, rounded half away from zero
  function automatic logic signed [SAT_W-1:0] mulq(input logic signed [MUL_W-1:0] a,
                                                   input logic signed [MUL_W-1:0] b,
                                                   input int sh);
    logic              neg;
    logic [MUL_W-1:0]  ma;
    logic [MUL_W-1:0]  mb;
    logic [PROD_W-1:0] m;
    neg = a[MUL_W-1] ^ b[MUL_W-1];
    ma  = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
    mb  = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
    m   = PROD_W'(ma) * PROD_W'(mb);
    if (sh > 0) begin
      m = (m + (PROD_W'(1) << (sh - 1))) >> sh;
    end
    mulq = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic word_t sat32(input logic signed [SAT_W-1:0] v);
    if (v > MAX32) begin
      sat32 = 32'sh7fff_ffff;
    end else if (v < MIN32) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

FILE: rtl/etm_sin.sv
// ---------------------------------------------------------------------------
// etm_sin
// pipelined polynomial sine of a 32-bit binary angle
// ---------------------------------------------------------------------------
module etm_sin import etm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_v,
  input  logic [31:0] phase,
  output logic        out_v,
  output trig_t       value
);

  logic [SIN_LAT-1:0] v;
  logic [1:0]  q1, q2, q3, q4;
  logic [30:0] x1, x2, x3, x4;
  logic [30:0] sq2, sq3;
  logic [29:0] t3;
  logic [30:0] p4;

  logic [30:0] xin;
  logic [61:0] xx;
  logic [57:0] kc;
  logic [60:0] tt;
  logic [61:0] px;
  logic [32:0] rnd;
  logic [TRIG_FRAC_BITS:0] smag;

  // fold into the first quarter
  assign xin  = phase[30] ? Q30_ONE - {1'b0, phase[29:0]} : {1'b0, phase[29:0]};
  assign xx   = 62'(x1) * 62'(x1);
  assign kc   = 58'(K_C) * 58'(sq2);
  assign tt   = 61'(t3) * 61'(sq3);
  assign px   = 62'(p4) * 62'(x4);
  assign rnd  = {1'b0, px[61:30]} + SIN_RND;
  assign smag = rnd[30 - TRIG_FRAC_BITS +: TRIG_FRAC_BITS + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[SIN_LAT-2:0], in_v};
    end
    q1  <= phase[31:30];
    x1  <= xin;
    q2  <= q1;
    x2  <= x1;
    sq2 <= xx[60:30];
    q3  <= q2;
    x3  <= x2;
    sq3 <= sq2;
    t3  <= K_B - 30'(kc[57:30]);
    q4  <= q3;
    x4  <= x3;
    p4  <= K_A - tt[60:30];
    value <= q4[1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
  end

  assign out_v = v[SIN_LAT-1];

endmodule

FILE: rtl/etm_rot.sv
// ---------------------------------------------------------------------------
// etm_rot
// two-stage product tree forming the y-x-z rotation matrix
// ---------------------------------------------------------------------------
module etm_rot import etm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_v,
  input  trig_set_t trig,
  output logic      out_v,
  output mat_t      m
);

  logic  v1;
  elem_t c1c3, s1s2, c1s2, c3s1, c1s3, c2s3, c2c3, c2s1, c1c2, s1s3;
  elem_t s2d, s3d;

  function automatic elem_t pq(input logic signed [MUL_W-1:0] a,
                               input logic signed [MUL_W-1:0] b);
    logic signed [SAT_W-1:0] p;
    p  = mulq(a, b, TRIG_FRAC_BITS);
    pq = p[ELEM_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      out_v <= 1'b0;
    end else begin
      v1    <= in_v;
      out_v <= v1;
    end
    c1c3 <= pq(MUL_W'(trig.c1), MUL_W'(trig.c3));
    s1s2 <= pq(MUL_W'(trig.s1), MUL_W'(trig.s2));
    c1s2 <= pq(MUL_W'(trig.c1), MUL_W'(trig.s2));
    c3s1 <= pq(MUL_W'(trig.c3), MUL_W'(trig.s1));
    c1s3 <= pq(MUL_W'(trig.c1), MUL_W'(trig.s3));
    c2s3 <= pq(MUL_W'(trig.c2), MUL_W'(trig.s3));
    c2c3 <= pq(MUL_W'(trig.c2), MUL_W'(trig.c3));
    c2s1 <= pq(MUL_W'(trig.c2), MUL_W'(trig.s1));
    c1c2 <= pq(MUL_W'(trig.c1), MUL_W'(trig.c2));
    s1s3 <= pq(MUL_W'(trig.s1), MUL_W'(trig.s3));
    s2d  <= ELEM_W'(trig.s2);
    s3d  <= ELEM_W'(trig.s3);
    // second level of the triple products, then the sums
    m[0][0] <= c1c3 + pq(MUL_W'(s1s2), MUL_W'(s3d));
    m[0][1] <= c2s3;
    m[0][2] <= pq(MUL_W'(c1s2), MUL_W'(s3d)) - c3s1;
    m[1][0] <= pq(MUL_W'(c3s1), MUL_W'(s2d)) - c1s3;
    m[1][1] <= c2c3;
    m[1][2] <= pq(MUL_W'(c1c3), MUL_W'(s2d)) + s1s3;
    m[2][0] <= c2s1;
    m[2][1] <= -s2d;
    m[2][2] <= c1c2;
  end

endmodule

FILE: rtl/etm_div.sv
// ---------------------------------------------------------------------------
// etm_div
// pipelined restoring divider, one quotient bit per stage, for the normal
// matrix entries
// ---------------------------------------------------------------------------
module etm_div import etm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_v,
  input  elem_t  r,
  input  scale_t sc,
  output logic   out_v,
  output word_t  q
);

  logic [NUMW:0]  v;
  logic [NUMW-1:0] n   [NUMW+1];
  logic [REMW-1:0] rem [NUMW+1];
  logic [15:0]     den [NUMW+1];
  logic            neg [NUMW+1];
  logic            zsc [NUMW+1];
  logic            rpos [NUMW+1];
  logic            rneg [NUMW+1];

  logic [REMW-1:0] shv   [NUMW];
  logic            ge    [NUMW];
  logic [REMW-1:0] rem_c [NUMW];
  logic [NUMW-1:0] n_c   [NUMW];

  logic [ELEM_W-1:0] rmag;
  logic [15:0]       smag;
  logic signed [SAT_W-1:0] qs;

  assign rmag = r[ELEM_W-1] ? ELEM_W'(-r) : ELEM_W'(r);
  assign smag = sc[15] ? 16'(-sc) : 16'(sc);

  always_comb begin
    for (int k = 0; k < NUMW; k++) begin
      shv[k]   = {rem[k][REMW-2:0], n[k][NUMW-1]};
      ge[k]    = shv[k] >= REMW'(den[k]);
      rem_c[k] = ge[k] ? shv[k] - REMW'(den[k]) : shv[k];
      n_c[k]   = {n[k][NUMW-2:0], ge[k]};
    end
  end

  assign qs = $signed({{(SAT_W - NUMW){1'b0}}, n[NUMW]});

  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      out_v <= 1'b0;
    end else begin
      v     <= {v[NUMW-1:0], in_v};
      out_v <= v[NUMW];
    end
    // rounding folded in as half the divisor
    n[0]    <= NUMW'(NUMW'(rmag) << (24 - TRIG_FRAC_BITS)) + NUMW'(smag >> 1);
    rem[0]  <= '0;
    den[0]  <= smag;
    neg[0]  <= r[ELEM_W-1] ^ sc[15];
    zsc[0]  <= (sc == '0);
    rpos[0] <= !r[ELEM_W-1] && (r != '0);
    rneg[0] <= r[ELEM_W-1];
    for (int k = 0; k < NUMW; k++) begin
      n[k+1]    <= n_c[k];
      rem[k+1]  <= rem_c[k];
      den[k+1]  <= den[k];
      neg[k+1]  <= neg[k];
      zsc[k+1]  <= zsc[k];
      rpos[k+1] <= rpos[k];
      rneg[k+1] <= rneg[k];
    end
    if (zsc[NUMW]) begin
      q <= rpos[NUMW] ? 32'sh7fff_ffff : (rneg[NUMW] ? 32'sh8000_0000 : 32'sh0);
    end else begin
      q <= sat32(neg[NUMW] ? -qs : qs);
    end
  end

endmodule

FILE: rtl/euler_transform_matrix_top.sv
// ---------------------------------------------------------------------------
// euler_transform_matrix_top
// y-x-z euler angles, scale and translation to model and normal columns
// ---------------------------------------------------------------------------
// usage:
//   raise start with a transform word on rot_*, scale_*, trans_*; it is taken
//   at a clock edge where busy is low. busy then stays high until the busy
//   count has run down to zero; no new transform is taken while busy is high.
//   each transform gives 7 result words on consecutive cycles, each marked by
//   result_strobe for one cycle: model columns 0..2, the translation, then
//   normal columns 0..2 (which_matrix = 1); last marks the seventh.
//   the first result strobe follows the accepting edge through the input
//   registers, sine pipeline 5, rotation products 2, a 27-stage divider
//   plus its entry and exit registers, and the collect register.
//   the receiver cannot hold results off; the pipeline never stalls.
//   synchronous reset clears all valid bits, the busy count and the result
//   sequencer; results in flight are dropped.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module euler_transform_matrix_top import etm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  logic [15:0]  rot_x,
  input  logic [15:0]  rot_y,
  input  logic [15:0]  rot_z,
  input  scale_t       scale_x,
  input  scale_t       scale_y,
  input  scale_t       scale_z,
  input  word_t        trans_x,
  input  word_t        trans_y,
  input  word_t        trans_z,
  output logic         result_strobe,
  output logic         which_matrix,
  output logic [1:0]   column,
  output word_t        elem_x,
  output word_t        elem_y,
  output word_t        elem_z,
  output logic         zero_scale,
  output logic         last
);

  logic        accept;
  logic [2:0]  bcnt;
  logic        in_v;
  logic [15:0] rx, ry, rz;
  side_t       side_in;

  logic [31:0] ph_x, ph_y, ph_z;
  trig_set_t   trig;
  logic        sin_v;

  side_t       side_d [SIDE_LAT];
  logic        rot_v;
  mat_t        m;
  late_t       late_d [DIV_LAT];

  logic        dv [3][3];
  word_t       nq [3][3];

  res_t        res_buf [NUM_RES];
  logic        active;
  logic [2:0]  idx;
  logic        load;
  late_t       lt;

  assign accept = start && !busy;
  assign busy   = (bcnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      bcnt <= '0;
      in_v <= 1'b0;
    end else begin
      in_v <= accept;
      if (accept) begin
        bcnt <= ACCEPT_GAP;
      end else if (bcnt != '0) begin
        bcnt <= bcnt - 3'd1;
      end
    end
    if (accept) begin
      rx <= rot_x;
      ry <= rot_y;
      rz <= rot_z;
      side_in.sc <= {scale_z, scale_y, scale_x};
      side_in.tr <= {trans_z, trans_y, trans_x};
    end
  end

  assign ph_x = {rx, 16'h0} & PHASE_MASK;
  assign ph_y = {ry, 16'h0} & PHASE_MASK;
  assign ph_z = {rz, 16'h0} & PHASE_MASK;

  etm_sin u_s1 (.clk, .rst, .in_v, .phase(ph_y), .out_v(sin_v), .value(trig.s1));
  etm_sin u_c1 (.clk, .rst, .in_v, .phase(ph_y + QUARTER_TURN), .out_v(), .value(trig.c1));
  etm_sin u_s2 (.clk, .rst, .in_v, .phase(ph_x), .out_v(), .value(trig.s2));
  etm_sin u_c2 (.clk, .rst, .in_v, .phase(ph_x + QUARTER_TURN), .out_v(), .value(trig.c2));
  etm_sin u_s3 (.clk, .rst, .in_v, .phase(ph_z), .out_v(), .value(trig.s3));
  etm_sin u_c3 (.clk, .rst, .in_v, .phase(ph_z + QUARTER_TURN), .out_v(), .value(trig.c3));

  etm_rot u_rot (.clk, .rst, .in_v(sin_v), .trig, .out_v(rot_v), .m);

  // scale and translation ride alongside the trig and divider pipelines
  always_ff @(posedge clk) begin
    side_d[0] <= side_in;
    for (int k = 1; k < SIDE_LAT; k++) begin
      side_d[k] <= side_d[k-1];
    end
    late_d[0].m <= m;
    late_d[0].s <= side_d[SIDE_LAT-1];
    for (int k = 1; k < DIV_LAT; k++) begin
      late_d[k] <= late_d[k-1];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_col
    for (genvar i = 0; i < 3; i++) begin : g_row
      etm_div u_div (
        .clk, .rst,
        .in_v (rot_v),
        .r    (m[j][i]),
        .sc   (side_d[SIDE_LAT-1].sc[j]),
        .out_v(dv[j][i]),
        .q    (nq[j][i])
      );
    end
  end

  assign load = dv[0][0];
  assign lt   = late_d[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (active) begin
      active <= (idx != LAST_IDX);
      idx    <= idx + 3'd1;
    end
    if (load) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          res_buf[j].e[i] <= sat32(mulq(MUL_W'(lt.m[j][i]), MUL_W'(lt.s.sc[j]),
                                        TRIG_FRAC_BITS - 8));
          res_buf[4+j].e[i] <= nq[j][i];
        end
        res_buf[j].zs   <= 1'b0;
        res_buf[4+j].zs <= (lt.s.sc[j] == '0);
      end
      res_buf[3].e  <= lt.s.tr;
      res_buf[3].zs <= 1'b0;
    end
  end

  // sequence order puts the matrix in idx bit 2 and the column in bits 1:0
  assign result_strobe = active;
  assign which_matrix  = idx[2];
  assign column        = idx[1:0];
  assign elem_x        = res_buf[idx].e[0];
  assign elem_y        = res_buf[idx].e[1];
  assign elem_z        = res_buf[idx].e[2];
  assign zero_scale    = res_buf[idx].zs;
  assign last          = (idx == LAST_IDX);

  `ETM_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
  `ETM_ASSERT(a_last_is_normal_col2, result_strobe && last, which_matrix && column == 2'd2)
  `ETM_ASSERT(a_zero_only_normal, result_strobe && zero_scale, which_matrix)
  `ETM_ASSERT_NEXT(a_words_back_to_back, result_strobe && !last, result_strobe)

endmodule
